[rtl/core/pds_pkg.sv]
// Package for the PLL divider search block: constants, lookup functions,
// and the command/status structs between controller and datapath.
// No dependencies.
package pds_pkg;

    localparam int unsigned KhzW   = 21;
    localparam int unsigned ReqW   = 12;
    localparam int unsigned BaseW  = 11;
    localparam int unsigned DvdW   = 24;
    localparam int unsigned DvsW   = 12;
    localparam int unsigned TrialW = 6;

    // kHz to MHz: (khz >> 3) / 125 by reciprocal, ceil(2^25 / 125)
    localparam int unsigned RecipW   = 19;
    localparam int unsigned ReqShift = 25;
    localparam int unsigned ProdW    = KhzW - 3 + RecipW;
    localparam logic [RecipW-1:0] REQ_RECIP = 19'd268436;

    localparam logic [6:0]  MULT_START = 7'((5500 / 27) / 2);
    localparam logic [5:0]  LAST_TRIAL = 6'(2 * ((5500 / 27) / 2 - (4500 / 27) / 2));
    localparam logic [13:0] PREC_SCALE = 14'd10000;
    localparam logic [13:0] HIGH_PHY   = 14'd3400;
    localparam logic [2:0]  LAST_LEVEL = 3'd5;
    localparam logic [2:0]  LAST_DIV   = 3'd7;

    typedef enum logic [1:0] {
        SEL_BASE,
        SEL_RATE,
        SEL_QUO
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     start;
        div_sel_t sel;
        logic     init_search;
        logic     advance;
        logic     load_out;
        logic     hit;
    } pds_cmd_t;

    typedef struct packed {
        logic div_done;
        logic req_zero;
        logic rate_ok;
        logic accept;
        logic last;
    } pds_status_t;

    function automatic logic [3:0] div_value(input logic [2:0] di);
        case (di)
            3'd0:    div_value = 4'd1;
            3'd1:    div_value = 4'd2;
            3'd2:    div_value = 4'd3;
            3'd3:    div_value = 4'd4;
            3'd4:    div_value = 4'd5;
            3'd5:    div_value = 4'd6;
            3'd6:    div_value = 4'd8;
            default: div_value = 4'd10;
        endcase
    endfunction

    function automatic logic [2:0] div_code(input logic [2:0] di);
        case (di)
            3'd0:    div_code = 3'd0;
            3'd1:    div_code = 3'd1;
            3'd2:    div_code = 3'd4;
            3'd3:    div_code = 3'd2;
            3'd4:    div_code = 3'd5;
            3'd5:    div_code = 3'd6;
            3'd6:    div_code = 3'd3;
            default: div_code = 3'd7;
        endcase
    endfunction

    function automatic logic [9:0] level_bound(input logic [2:0] lv);
        case (lv)
            3'd0:    level_bound = 10'd1;
            3'd1:    level_bound = 10'd5;
            3'd2:    level_bound = 10'd10;
            3'd3:    level_bound = 10'd50;
            3'd4:    level_bound = 10'd100;
            default: level_bound = 10'd1000;
        endcase
    endfunction

endpackage

[rtl/core/pds_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pds_pkg for widths.
module pds_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pds_pkg::DvdW-1:0]   dividend,
    input  logic [pds_pkg::DvsW-1:0]   divisor,
    output logic                       done,
    output logic [pds_pkg::DvdW-1:0]   quotient
);
    import pds_pkg::*;

    logic [DvsW-1:0] rem_reg, rem_next;
    logic [DvdW-1:0] quo_reg, quo_next;
    logic [DvsW-1:0] dvs_reg;
    logic [4:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DvsW:0]   trial;
    logic [DvsW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DvdW-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 5'(DvdW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DvsW-1:0];
                quo_next = {quo_reg[DvdW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DvsW-1:0];
                quo_next = {quo_reg[DvdW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/pds_datapath.sv]
// Datapath of the PLL divider search: candidate counters, shared divider,
// acceptance checks and the result register. Depends on pds_pkg, pds_divider.
module pds_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pds_pkg::pds_cmd_t           cmd,
    input  logic [pds_pkg::KhzW-1:0]    khz,
    output pds_pkg::pds_status_t        status,
    output logic [39:0]                 result
);
    import pds_pkg::*;

    logic [ReqW-1:0]   req_reg;
    logic [BaseW-1:0]  base_reg;
    logic [1:0]        rshift_reg;
    logic              rate_ok_reg;
    logic [DvdW-1:0]   q_reg;
    logic [2:0]        lv_reg;
    logic [2:0]        di_reg;
    logic [TrialW-1:0] t_reg;
    div_sel_t          sel_reg;
    logic [39:0]       result_reg;

    logic [ProdW-1:0]  req_prod;
    logic [TrialW-1:0] step;
    logic [6:0]        mult;
    logic [3:0]        dval;
    logic [3:0]        rval;
    logic [BaseW-1:0]  real_rate;
    logic [13:0]       phy;
    logic [DvdW-1:0]   dividend;
    logic [DvsW-1:0]   divisor;
    logic              div_done;
    logic [DvdW-1:0]   quotient;
    logic [DvdW-1:0]   err;

    // floor to MHz: exact for every 21-bit input
    assign req_prod = ProdW'(khz[KhzW-1:3]) * ProdW'(REQ_RECIP);

    // trial order 101, 100, 102, 99, 103, ...
    assign step = (t_reg + TrialW'(1)) >> 1;
    assign mult = t_reg[0] ? (MULT_START - 7'(step)) : (MULT_START + 7'(step));
    assign dval = div_value(di_reg);
    assign rval = 4'd1 << rshift_reg;
    assign real_rate = base_reg >> rshift_reg;
    assign phy = 14'(real_rate) * 14'd10;

    always_comb
    begin
        case (cmd.sel)
            SEL_BASE:
            begin
                dividend = DvdW'(13'(mult) * 13'd54);
                divisor  = DvsW'(dval) * DvsW'(5);
            end
            SEL_RATE:
            begin
                dividend = DvdW'(base_reg);
                divisor  = DvsW'(req_reg);
            end
            default:
            begin
                dividend = DvdW'(real_rate) * DvdW'(PREC_SCALE);
                divisor  = DvsW'(req_reg);
            end
        endcase
        if (q_reg >= DvdW'(PREC_SCALE))
        begin
            err = q_reg - DvdW'(PREC_SCALE);
        end
        else
        begin
            err = DvdW'(PREC_SCALE) - q_reg;
        end
    end

    pds_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= SEL_BASE;
            lv_reg  <= '0;
            di_reg  <= '0;
            t_reg   <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                sel_reg <= cmd.sel;
            end
            if (cmd.init_search)
            begin
                lv_reg <= '0;
                di_reg <= '0;
                t_reg  <= '0;
            end
            else if (cmd.advance)
            begin
                if (t_reg == LAST_TRIAL)
                begin
                    t_reg <= '0;
                    if (di_reg == LAST_DIV)
                    begin
                        di_reg <= '0;
                        lv_reg <= lv_reg + 3'd1;
                    end
                    else
                    begin
                        di_reg <= di_reg + 3'd1;
                    end
                end
                else
                begin
                    t_reg <= t_reg + TrialW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= req_prod[ReqShift +: ReqW];
        end
        if (div_done)
        begin
            case (sel_reg)
                SEL_BASE: base_reg <= BaseW'(quotient);
                SEL_RATE:
                begin
                    rate_ok_reg <= (quotient == DvdW'(1)) || (quotient == DvdW'(2))
                                || (quotient == DvdW'(4)) || (quotient == DvdW'(8));
                    rshift_reg  <= quotient[3] ? 2'd3 : quotient[2] ? 2'd2 :
                                   quotient[1] ? 2'd1 : 2'd0;
                end
                default:  q_reg    <= quotient;
            endcase
        end
        if (cmd.load_out)
        begin
            if (cmd.hit)
            begin
                result_reg <= {1'b0, (phy > HIGH_PHY), phy, lv_reg, rshift_reg,
                               div_code(di_reg), rval, dval, mult, 1'b1};
            end
            else
            begin
                result_reg <= '0;
            end
        end
    end

    assign status.div_done = div_done;
    assign status.req_zero = (req_reg == '0);
    assign status.rate_ok  = rate_ok_reg;
    assign status.accept   = (err < DvdW'(level_bound(lv_reg)));
    assign status.last     = (lv_reg == LAST_LEVEL) && (di_reg == LAST_DIV)
                          && (t_reg == LAST_TRIAL);
    assign result = result_reg;

endmodule

[rtl/core/pds_ctrl.sv]
// Controller of the PLL divider search: sequences the divisions of each
// candidate and the stream handshakes. Depends on pds_pkg.
module pds_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pds_pkg::pds_status_t  status,
    output pds_pkg::pds_cmd_t     cmd
);
    import pds_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WAIT_BASE,
        ST_WAIT_RATE,
        ST_START_RATE,
        ST_CHK_RATE,
        ST_WAIT_QUO,
        ST_CHK_QUO,
        ST_NEXT,
        ST_FINISH
    } state_t;

    state_t   state_reg, state_next;
    logic     hit_reg, hit_next;
    logic     out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.sel        = SEL_BASE;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                // MHz floor is registered with the transaction
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    hit_next    = 1'b1;
                    state_next  = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                // hit_reg here marks first entry after the transaction
                if (hit_reg)
                begin
                    hit_next = 1'b0;
                    if (status.req_zero)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.init_search = 1'b1;
                        state_next      = ST_WAIT_BASE;
                    end
                end
                else if (status.last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_WAIT_BASE;
                end
            end
            ST_WAIT_BASE:
            begin
                cmd.start  = 1'b1;
                cmd.sel    = SEL_BASE;
                state_next = ST_WAIT_RATE;
            end
            ST_WAIT_RATE:
            begin
                // base is registered on this done
                if (status.div_done)
                begin
                    state_next = ST_START_RATE;
                end
            end
            ST_START_RATE:
            begin
                cmd.start  = 1'b1;
                cmd.sel    = SEL_RATE;
                state_next = ST_CHK_RATE;
            end
            ST_CHK_RATE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_WAIT_QUO;
                end
            end
            ST_WAIT_QUO:
            begin
                if (status.rate_ok)
                begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_QUO;
                    state_next = ST_CHK_QUO;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_CHK_QUO:
            begin
                if (status.div_done)
                begin
                    state_next = ST_CHK_QUO;
                    hit_next   = 1'b1;
                end
                if (hit_reg)
                begin
                    hit_next = status.accept;
                    state_next = status.accept ? ST_FINISH : ST_NEXT;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.hit        = hit_reg;
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/core/pll_divider_search.sv]
// PLL divider search top level: controller plus datapath.
// Per candidate: the base and rate divisions run in one shared restoring divider,
// and the error division follows only when the rate passes; up to 1776 candidates.
// A request below 1 MHz skips the search and gets a not-found result.
// Throughput: one transaction at a time; the next is taken once the result is queued.
// Reset: rst_n asynchronous active low clears control state; no clearing pass.
// Depends on pds_pkg, pds_ctrl, pds_datapath, pds_divider.
module pll_divider_search
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] pixel_clock_khz
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // found, multiplier, clock_divider, rate_divider,
                                   // divider_code, rate_code, precision_level,
                                   // phy_clock, high_ratio
);
    import pds_pkg::*;

    pds_cmd_t    cmd;
    pds_status_t status;

    pds_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pds_datapath u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .khz    (s_tdata[KhzW-1:0]),
        .status (status),
        .result (m_tdata)
    );

endmodule

[verif/pll_divider_search_tb.sv]
// Testbench for pll_divider_search: drives requested pixel clocks, predicts the
// chosen PLL settings in a scoreboard class and checks every result transaction.
// Depends on pds_pkg and the pll_divider_search RTL.
`timescale 1ns / 100ps

module pll_divider_search_tb;

    import pds_pkg::*;

    typedef struct packed {
        logic        high_ratio;
        logic [13:0] phy_clock;
        logic [2:0]  precision_level;
        logic [1:0]  rate_code;
        logic [2:0]  divider_code;
        logic [3:0]  rate_divider;
        logic [3:0]  clock_divider;
        logic [6:0]  multiplier;
        logic        found;
    } pll_setting_t;

    class pll_scoreboard;
        pll_setting_t pending_settings[$];
        int           mismatches;
        int           results_seen;

        function automatic pll_setting_t search_setting(logic [20:0] khz);
            int unsigned  dividers[8] = '{1, 2, 3, 4, 5, 6, 8, 10};
            int unsigned  codes[8]    = '{0, 1, 4, 2, 5, 6, 3, 7};
            int unsigned  bounds[6]   = '{1, 5, 10, 50, 100, 1000};
            int unsigned  req, m, d, base, r, rate_val, q, err, phy;
            pll_setting_t s;
            s = '0;
            req = khz / 1000;
            if (req == 0)
                return s;
            for (int lv = 0; lv < 6; lv++)
                for (int di = 0; di < 8; di++)
                    for (int t = 0; t < 37; t++)
                    begin
                        // multiplier walks outward from 101: 101,100,102,...,83,119
                        if (t == 0)
                            m = 101;
                        else if (t % 2 == 1)
                            m = 101 - (t + 1) / 2;
                        else
                            m = 101 + t / 2;
                        d = dividers[di];
                        base = (2 * m * 27) / d / 5;
                        r = base / req;
                        if (r != 1 && r != 2 && r != 4 && r != 8)
                            continue;
                        rate_val = base / r;
                        q = rate_val * 10000 / req;
                        err = (q >= 10000) ? q - 10000 : 10000 - q;
                        if (err >= bounds[lv])
                            continue;
                        phy = rate_val * 10;
                        s.found           = 1'b1;
                        s.multiplier      = 7'(m);
                        s.clock_divider   = 4'(d);
                        s.rate_divider    = 4'(r);
                        s.divider_code    = 3'(codes[di]);
                        s.rate_code       = (r == 1) ? 2'd0 : (r == 2) ? 2'd1 :
                                            (r == 4) ? 2'd2 : 2'd3;
                        s.precision_level = 3'(lv);
                        s.phy_clock       = 14'(phy);
                        s.high_ratio      = (phy > 3400);
                        return s;
                    end
            return s;
        endfunction

        function void note_request(logic [20:0] khz);
            pending_settings.push_back(search_setting(khz));
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [39:0] data);
            pll_setting_t got, want;
            got = data[38:0];
            results_seen++;
            if (pending_settings.size() == 0)
            begin
                report("unexpected transaction, found", got.found, 0);
                return;
            end
            want = pending_settings.pop_front();
            if (got.found != want.found)
                report("found", got.found, want.found);
            if (got.multiplier != want.multiplier)
                report("multiplier", got.multiplier, want.multiplier);
            if (got.clock_divider != want.clock_divider)
                report("clock_divider", got.clock_divider, want.clock_divider);
            if (got.rate_divider != want.rate_divider)
                report("rate_divider", got.rate_divider, want.rate_divider);
            if (got.divider_code != want.divider_code)
                report("divider_code", got.divider_code, want.divider_code);
            if (got.rate_code != want.rate_code)
                report("rate_code", got.rate_code, want.rate_code);
            if (got.precision_level != want.precision_level)
                report("precision_level", got.precision_level, want.precision_level);
            if (got.phy_clock != want.phy_clock)
                report("phy_clock", got.phy_clock, want.phy_clock);
            if (got.high_ratio != want.high_ratio)
                report("high_ratio", got.high_ratio, want.high_ratio);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    pll_scoreboard sb = new();
    int unsigned   send_idle_pct;
    int unsigned   recv_stall_pct;
    int unsigned   hold_cycles;
    int unsigned   degraded_count;

    always #5 clk = ~clk;

    pll_divider_search u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // receiver: random stalls plus one long hold-off
    initial
    begin
        logic [39:0] data;
        logic        taken;
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            @(negedge clk);
            taken = m_tvalid && m_tready;
            data  = m_tdata;
            @(posedge clk);
            if (taken)
            begin
                if (data[23:21] > 1)
                    degraded_count++;
                sb.check_result(data);
            end
        end
    end

    // tvalid stays high after the accepting edge; the next call or the caller drops it
    task send_request(logic [20:0] khz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, khz};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        sb.note_request(khz);
    endtask

    task wait_drained();
        while (sb.pending_settings.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [20:0] random_request();
        if ($urandom_range(9) == 0)
            return 21'($urandom_range(2097151));
        return 21'($urandom_range(600000, 20000));
    endfunction

    initial
    begin
        logic [20:0] directed[$] = '{21'd0, 21'd999, 21'd1000, 21'd25175, 21'd27000,
                                     21'd65000, 21'd74250, 21'd108000, 21'd148500,
                                     21'd162000, 21'd297000, 21'd594000, 21'd643000,
                                     21'd1285999, 21'd1286000, 21'd2097151};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            // sender pauses until the block has returned everything
            wait_drained();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (ph == 0)
                hold_cycles = 20000;
            for (int n = 0; n < 25; n++)
                send_request(random_request());
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (200) @(posedge clk);
        $display("covered %0d results, %0d at degraded precision, under four idle/stall mixes",
                 sb.results_seen, degraded_count);
        if (sb.mismatches == 0 && sb.pending_settings.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #1000000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
